### sv/src_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// src_pkg
// Shared types and constants of the stepper ramp controller: operation codes,
// register indexes, reset values, controller states and control structs.
// ----------------------------------------------------------------------------
package src_pkg;

    localparam int TARGET_W  = 20;
    localparam int INTERV_W  = 24;
    localparam int RAMP_W    = 16;
    localparam int STEPS_W   = 31;
    localparam int PROD_W    = INTERV_W + RAMP_W;
    localparam int DIV_CNT_W = 5;

    localparam logic [1:0] OP_TICK = 2'd0;
    localparam logic [1:0] OP_MOVE = 2'd1;
    localparam logic [1:0] OP_STOP = 2'd2;

    localparam logic [1:0] CFG_TARGET  = 2'd0;
    localparam logic [1:0] CFG_STARTUP = 2'd1;
    localparam logic [1:0] CFG_SETTLE  = 2'd2;
    localparam logic [1:0] CFG_RAMP    = 2'd3;

    localparam logic [TARGET_W-1:0] TARGET_RST  = 20'd2000;
    localparam logic [INTERV_W-1:0] STARTUP_RST = 24'd10000;
    localparam logic [INTERV_W-1:0] SETTLE_RST  = 24'd0;
    localparam logic [RAMP_W-1:0]   RAMP_RST    = 16'd1;

    localparam logic [INTERV_W-1:0]  ELAPSED_MAX = 24'hFF_FFFF;
    localparam logic [DIV_CNT_W-1:0] DIV_LAST    = 5'd23;
    localparam logic [31:0]          MOVE_MIN_NEG = 32'h8000_0000;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_MUL,
        ST_DIV,
        ST_RAMP,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic capture;
        logic eval;
        logic mul;
        logic div_step;
        logic ramp_load;
        logic emit;
    } t_dp_cmd;

    typedef struct packed {
        logic need_ramp;
        logic div_last;
        logic out_free;
    } t_dp_status;

    function automatic logic [3:0] coil_pattern(input logic [1:0] phase);
        logic [3:0] pat;
        case (phase)
            2'd0: pat = 4'h3;
            2'd1: pat = 4'h6;
            2'd2: pat = 4'hC;
            2'd3: pat = 4'h9;
            default: pat = 4'h0;
        endcase
        return pat;
    endfunction

endpackage

### sv/src_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// src_ctrl
// Sequencer: takes a request, evaluates it, runs the ramp multiply and
// divide when a step needs a new interval, then hands the result out.
// ----------------------------------------------------------------------------
module src_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    output src_pkg::t_dp_cmd    o_cmd,
    input  src_pkg::t_dp_status i_status
);
    import src_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) n_state = ST_EVAL;
            end
            ST_EVAL: begin
                n_state = i_status.need_ramp ? ST_MUL : ST_EMIT;
            end
            ST_MUL:  n_state = ST_DIV;
            ST_DIV: begin
                if (i_status.div_last) n_state = ST_RAMP;
            end
            ST_RAMP: n_state = ST_EMIT;
            ST_EMIT: begin
                if (i_status.out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.capture = i_in_valid;
            end
            ST_EVAL: o_cmd.eval      = 1'b1;
            ST_MUL:  o_cmd.mul       = 1'b1;
            ST_DIV:  o_cmd.div_step  = 1'b1;
            ST_RAMP: o_cmd.ramp_load = 1'b1;
            ST_EMIT: o_cmd.emit      = i_status.out_free;
            default: o_in_ready = 1'b0;
        endcase
    end

endmodule

### sv/src_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// src_dp
// Datapath: configuration registers, motion state, ramp multiplier, a
// one-bit-per-cycle divider and the result register.
// ----------------------------------------------------------------------------
module src_dp (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  src_pkg::t_dp_cmd           i_cmd,
    output src_pkg::t_dp_status        o_status,
    input  logic                       i_cfg_valid,
    input  logic [1:0]                 i_cfg_index,
    input  logic [31:0]                i_cfg_data,
    input  logic [1:0]                 i_op,
    input  logic [31:0]                i_move_steps,
    input  logic                       i_out_ready,
    output logic                       o_out_valid,
    output logic [3:0]                 o_coils,
    output logic                       o_busy_res,
    output logic                       o_stepped,
    output logic                       o_done_res
);
    import src_pkg::*;

    // configuration
    logic [TARGET_W-1:0] r_target;
    logic [INTERV_W-1:0] r_startup;
    logic [INTERV_W-1:0] r_settle;
    logic [RAMP_W-1:0]   r_ramp_len;

    // captured request
    logic [1:0]  r_op;
    logic [31:0] r_move;

    // motion state
    logic [1:0]          r_phase,    n_phase;
    logic                r_rev,      n_rev;
    logic [STEPS_W-1:0]  r_left,     n_left;
    logic [STEPS_W-1:0]  r_done_cnt, n_done_cnt;
    logic [INTERV_W-1:0] r_active,   n_active;
    logic [INTERV_W-1:0] r_elapsed,  n_elapsed;
    logic                r_settling, n_settling;
    logic                r_running,  n_running;
    logic                r_stepped,  n_stepped;
    logic                r_done,     n_done;

    // ramp arithmetic
    logic [RAMP_W-1:0]    r_rem,  n_rem;
    logic [INTERV_W-1:0]  r_low,  n_low;
    logic [DIV_CNT_W-1:0] r_cnt,  n_cnt;

    // result register
    logic       r_out_valid;
    logic [3:0] r_coils;
    logic       r_busy;
    logic       r_out_stepped;
    logic       r_out_done;

    logic [INTERV_W-1:0] w_target_x;
    logic [INTERV_W-1:0] w_start;
    logic [INTERV_W-1:0] w_diff;
    logic [RAMP_W-1:0]   w_len;
    logic [RAMP_W-1:0]   w_k;
    logic [PROD_W-1:0]   w_prod;
    logic [RAMP_W:0]     w_trial;
    logic                w_ge;
    logic [31:0]         w_abs;
    logic [INTERV_W-1:0] w_el_inc;
    logic [STEPS_W-1:0]  w_left_dec;
    logic                w_need_ramp;

    assign w_target_x = {{(INTERV_W-TARGET_W){1'b0}}, r_target};
    assign w_start    = (r_startup > w_target_x) ? r_startup : w_target_x;
    assign w_diff     = w_start - w_target_x;
    assign w_len      = (r_ramp_len == '0) ? {{(RAMP_W-1){1'b0}}, 1'b1} : r_ramp_len;
    assign w_k        = (r_done_cnt > {{(STEPS_W-RAMP_W){1'b0}}, w_len}) ?
                        w_len : r_done_cnt[RAMP_W-1:0];
    assign w_prod     = {{RAMP_W{1'b0}}, w_diff} * {{INTERV_W{1'b0}}, w_k};
    assign w_trial    = {r_rem, r_low[INTERV_W-1]};
    assign w_ge       = w_trial >= {1'b0, w_len};
    assign w_abs      = r_move[31] ? (32'd0 - r_move) : r_move;
    assign w_el_inc   = (r_elapsed < ELAPSED_MAX) ? (r_elapsed + 1'b1) : r_elapsed;
    assign w_left_dec = (r_left != '0) ? (r_left - 1'b1) : r_left;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target   <= TARGET_RST;
            r_startup  <= STARTUP_RST;
            r_settle   <= SETTLE_RST;
            r_ramp_len <= RAMP_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_TARGET:  r_target   <= i_cfg_data[TARGET_W-1:0];
                CFG_STARTUP: r_startup  <= i_cfg_data[INTERV_W-1:0];
                CFG_SETTLE:  r_settle   <= i_cfg_data[INTERV_W-1:0];
                CFG_RAMP:    r_ramp_len <= i_cfg_data[RAMP_W-1:0];
                default:     r_target   <= r_target;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op   <= i_op;
            r_move <= i_move_steps;
        end
    end

    // evaluate one request, then ramp arithmetic
    always_comb begin
        n_phase     = r_phase;
        n_rev       = r_rev;
        n_left      = r_left;
        n_done_cnt  = r_done_cnt;
        n_active    = r_active;
        n_elapsed   = r_elapsed;
        n_settling  = r_settling;
        n_running   = r_running;
        n_stepped   = r_stepped;
        n_done      = r_done;
        n_rem       = r_rem;
        n_low       = r_low;
        n_cnt       = r_cnt;
        w_need_ramp = 1'b0;
        if (i_cmd.eval) begin
            n_stepped = 1'b0;
            n_done    = 1'b0;
            case (r_op)
                OP_MOVE: begin
                    if (r_move != '0 && r_move != MOVE_MIN_NEG) begin
                        n_rev      = r_move[31];
                        n_left     = w_abs[STEPS_W-1:0];
                        n_done_cnt = '0;
                        n_active   = w_start;
                        n_settling = 1'b1;
                        n_running  = 1'b1;
                        n_elapsed  = '0;
                    end
                end
                OP_STOP: begin
                    n_running  = 1'b0;
                    n_settling = 1'b0;
                    n_left     = '0;
                end
                OP_TICK: begin
                    if (r_running) begin
                        n_elapsed = w_el_inc;
                        if (r_settling) begin
                            if (w_el_inc >= r_settle) begin
                                n_settling = 1'b0;
                                n_elapsed  = '0;
                            end
                        end else if (w_el_inc >= r_active) begin
                            n_elapsed  = '0;
                            n_phase    = r_rev ? (r_phase - 1'b1) : (r_phase + 1'b1);
                            n_done_cnt = r_done_cnt + 1'b1;
                            n_stepped  = 1'b1;
                            n_left     = w_left_dec;
                            if (w_left_dec == '0) begin
                                n_running  = 1'b0;
                                n_settling = 1'b0;
                                n_done     = 1'b1;
                            end else if (r_active <= w_target_x) begin
                                n_active = w_target_x;
                            end else begin
                                w_need_ramp = 1'b1;
                            end
                        end
                    end
                end
                default: n_done = 1'b0;
            endcase
        end
        if (i_cmd.mul) begin
            // dividend below len * 2^24, so the top bits already sit below len
            n_rem = w_prod[PROD_W-1:INTERV_W];
            n_low = w_prod[INTERV_W-1:0];
            n_cnt = '0;
        end
        if (i_cmd.div_step) begin
            n_rem = w_ge ? (w_trial[RAMP_W-1:0] - w_len) : w_trial[RAMP_W-1:0];
            n_low = {r_low[INTERV_W-2:0], w_ge};
            n_cnt = r_cnt + 1'b1;
        end
        if (i_cmd.ramp_load) begin
            n_active = w_start - r_low;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= '0;
            r_rev      <= 1'b0;
            r_left     <= '0;
            r_done_cnt <= '0;
            r_active   <= '0;
            r_elapsed  <= '0;
            r_settling <= 1'b0;
            r_running  <= 1'b0;
            r_stepped  <= 1'b0;
            r_done     <= 1'b0;
        end else begin
            r_phase    <= n_phase;
            r_rev      <= n_rev;
            r_left     <= n_left;
            r_done_cnt <= n_done_cnt;
            r_active   <= n_active;
            r_elapsed  <= n_elapsed;
            r_settling <= n_settling;
            r_running  <= n_running;
            r_stepped  <= n_stepped;
            r_done     <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_low <= n_low;
        r_cnt <= n_cnt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_coils       <= r_running ? coil_pattern(r_phase) : 4'h0;
            r_busy        <= r_running;
            r_out_stepped <= r_stepped;
            r_out_done    <= r_done;
        end
    end

    assign o_status.need_ramp = w_need_ramp;
    assign o_status.div_last  = (r_cnt == DIV_LAST);
    assign o_status.out_free  = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_coils     = r_coils;
    assign o_busy_res  = r_busy;
    assign o_stepped   = r_out_stepped;
    assign o_done_res  = r_out_done;

`ifndef SYNTHESIS
    a_settle_needs_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_settling |-> r_running)
        else $error("settle phase held while not running");

    a_emit_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |=> r_out_valid)
        else $error("result lost after emit");

    a_ramp_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.ramp_load |=> r_active >= $past(w_target_x))
        else $error("ramped interval fell below target");
`endif

endmodule

### sv/stepper_ramp_controller_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stepper_ramp_controller_core
// Full-step stepper drive with settle hold and a linear start-up ramp.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries one request: op 0 is a
//   one-microsecond tick, op 1 a signed move of i_move_steps, op 2 stop.
//   Every request gives exactly one result on the output channel
//   (o_out_valid / i_out_ready): coil drive, busy, stepped and done flags.
//   Configuration writes (i_cfg_valid / o_cfg_ready, always ready) load the
//   register at i_cfg_index from i_cfg_data: 0 target, 1 startup, 2 settle,
//   3 ramp length. Write only while no request is in flight.
// Timing:
//   o_out_valid rises once a request has passed the evaluate and emit
//   states when no ramp update is needed. A step that recomputes the
//   interval also passes multiply, the one-bit-per-cycle divider (24
//   quotient bits) and load between evaluate and emit.
//   One request is in flight at a time; the next is taken once the result
//   sits in the output register, so a waiting result does not stall intake.
// Reset:
//   Synchronous, active low; config, motion state and o_out_valid reset, so
//   no result is pending; o_coils is not reset. If the receiver stalls, the
//   result holds and the following request waits before its hand-off.
// ----------------------------------------------------------------------------
module stepper_ramp_controller_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_op,
    input  logic signed [31:0] i_move_steps,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [3:0]  o_coils,
    output logic        o_busy_res,
    output logic        o_stepped,
    output logic        o_done_res,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);
    import src_pkg::*;

    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    // configuration registers never back-pressure
    assign o_cfg_ready = 1'b1;

    src_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .o_cmd      (w_cmd),
        .i_status   (w_status)
    );

    src_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_status     (w_status),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_op         (i_op),
        .i_move_steps (i_move_steps),
        .i_out_ready  (i_out_ready),
        .o_out_valid  (o_out_valid),
        .o_coils      (o_coils),
        .o_busy_res   (o_busy_res),
        .o_stepped    (o_stepped),
        .o_done_res   (o_done_res)
    );

`ifndef SYNTHESIS
    a_done_is_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_done_res) |-> (o_stepped && !o_busy_res))
        else $error("done reported without final step or while busy");

    a_idle_released: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_busy_res) |-> (o_coils == 4'h0))
        else $error("coils driven while idle");

    a_busy_two_coils: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_busy_res) |-> ($countones(o_coils) == 2))
        else $error("busy result without a two-coil pattern");
`endif

endmodule
